// ----- hdl/fbba_pkg.sv -----
// ============================================================================
// fbba_pkg : shared types and constants of the free block bitmap allocator
// Map geometry, command codes, the sequencer states and the structs that
// pass between the sequencer and the map memory.
// ============================================================================
package fbba_pkg;

   // Map geometry.
   localparam int NUM_BLOCKS      = 1024;
   localparam int RESERVED_BLOCKS = 51;
   localparam int MAX_RUN         = 16;
   localparam int WORD_BITS       = 32;
   localparam int MAP_WORDS       = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W           = $clog2(WORD_BITS);

   // Field widths fixed by the interface.
   localparam int CMD_W   = 3;
   localparam int BLK_W   = 10;
   localparam int WANT_W  = 5;
   localparam int CNT_W   = $clog2(MAX_RUN + 1);
   localparam int HIT_W   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

   // Stream word layout.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_FIND_ONE   = 3'd0,
      CMD_FIND_COUNT = 3'd1,
      CMD_MARK_USED  = 3'd2,
      CMD_MARK_FREE  = 3'd3,
      CMD_TEST       = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MODIFY,
      ST_REPLY,
      ST_EMIT
   } fsm_state_type;

   // One request as unpacked from the input word.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BLK_W-1:0]  block_index;
      logic [BLK_W-1:0]  range_start;
      logic [BLK_W-1:0]  range_end;
      logic [WANT_W-1:0] want_count;
   } req_type;

   // One access to the map memory.
   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic [WADDR_W-1:0]   addr;
      logic [WORD_BITS-1:0] wdata;
   } map_req_type;

   // Contents of a map word right after reset: reserved blocks used, rest free.
   function automatic logic [WORD_BITS-1:0] init_word(input logic [WADDR_W-1:0] w);
      logic [WORD_BITS-1:0] v;
      int                   blk;
      v = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         blk  = int'(w) * WORD_BITS + b;
         v[b] = (blk >= RESERVED_BLOCKS) && (blk < NUM_BLOCKS);
      end
      return v;
   endfunction

endpackage

// ----- hdl/fbba_map_mem.sv -----
// ============================================================================
// fbba_map_mem : free map storage
// One word-wide synchronous memory with a registered read port, plus the
// sweep that writes the reset contents after reset.
// ============================================================================
module fbba_map_mem
   import fbba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  map_req_type          mem_req,
   output logic [WORD_BITS-1:0] rd_data,
   output logic                 init_done
);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];

   logic [WADDR_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic               clr_busy_ff, clr_busy_in;

   logic                 wr_en;
   logic [WADDR_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   always_comb begin
      clr_ptr_in  = clr_ptr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == WADDR_W'(MAP_WORDS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // The sweep owns the write port until every word holds its reset value.
   assign wr_en   = clr_busy_ff | mem_req.wr_en;
   assign wr_addr = clr_busy_ff ? clr_ptr_ff : mem_req.addr;
   assign wr_data = clr_busy_ff ? init_word(clr_ptr_ff) : mem_req.wdata;

   assign init_done = ~clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_ptr_ff  <= clr_ptr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data <= mem[mem_req.addr];
      end
   end

endmodule

// ----- hdl/fbba_engine.sv -----
// ============================================================================
// fbba_engine : command sequencer and word scanner
// Runs one command at a time against the map memory: scans range words for
// free bits, collects hits, does read-modify-write for marks, and drives the
// result register.
// ============================================================================
module fbba_engine
   import fbba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 init_done,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req,
   output map_req_type          mem_req,
   input  logic [WORD_BITS-1:0] rd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found,
   output logic [BLK_W-1:0]     rsp_block,
   output logic                 rsp_bit,
   output logic                 rsp_last
);

   fsm_state_type state_ff, state_in;

   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [BLK_W-1:0]     idx_ff, idx_in;
   logic [BLK_W-1:0]     rs_ff, rs_in;
   logic [BLK_W-1:0]     re_ff, re_in;
   logic [CNT_W-1:0]     want_ff, want_in;
   logic [WADDR_W-1:0]   word_ptr_ff, word_ptr_in;
   logic                 pend_ff, pend_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [CNT_W-1:0]     hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]     out_cnt_ff, out_cnt_in;
   logic [BLK_W-1:0]     hits_ff [MAX_RUN];
   logic                 hit_wr;
   logic [BLK_W-1:0]     hit_val;
   logic                 rep_found_ff, rep_found_in;
   logic                 rep_bit_ff, rep_bit_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [BLK_W-1:0]     rsp_block_ff, rsp_block_in;
   logic                 rsp_bit_ff, rsp_bit_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 fire;
   logic                 slot_free;
   logic [BLK_W-1:0]     re_clip;
   logic                 range_bad;
   logic                 idx_bad;
   logic [CNT_W-1:0]     want_sat;
   logic [WORD_BITS-1:0] lo_mask, hi_mask, cur_word, onehot, idx_bit;
   logic [BIT_W-1:0]     low_idx;
   logic                 ptr_at_end;
   logic                 run_full;
   logic                 emit_last;

   assign req_ready = (state_ff == ST_IDLE) && init_done;
   assign fire      = req_valid && req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // Request decode: clip the range end, clamp the wanted count to 1..MAX_RUN, flag bad ranges and indices.
   always_comb begin
      re_clip   = (32'(req.range_end) >= NUM_BLOCKS) ? BLK_W'(NUM_BLOCKS - 1) : req.range_end;
      range_bad = (32'(req.range_start) >= NUM_BLOCKS) || (req.range_start > re_clip);
      idx_bad   = 32'(req.block_index) >= NUM_BLOCKS;
      if (req.want_count == '0) begin
         want_sat = CNT_W'(1);
      end else if (32'(req.want_count) > MAX_RUN) begin
         want_sat = CNT_W'(MAX_RUN);
      end else begin
         want_sat = CNT_W'(req.want_count);
      end
   end

   // Current scan word: fresh memory data trimmed to the range, or the held word.
   always_comb begin
      lo_mask = '1;
      hi_mask = '1;
      if (word_ptr_ff == WADDR_W'(rs_ff >> BIT_W)) begin
         lo_mask = {WORD_BITS{1'b1}} << rs_ff[BIT_W-1:0];
      end
      if (word_ptr_ff == WADDR_W'(re_ff >> BIT_W)) begin
         hi_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - re_ff[BIT_W-1:0]);
      end
      cur_word = pend_ff ? (rd_data & lo_mask & hi_mask) : word_ff;
      onehot   = cur_word & (~cur_word + WORD_BITS'(1));
      low_idx  = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (onehot[j]) begin
            low_idx = low_idx | BIT_W'(j);
         end
      end
   end

   assign ptr_at_end = word_ptr_ff == WADDR_W'(re_ff >> BIT_W);
   assign run_full   = hit_cnt_ff == want_ff;
   assign emit_last  = out_cnt_ff == CNT_W'(hit_cnt_ff - 1'b1);
   assign idx_bit    = WORD_BITS'(1) << idx_ff[BIT_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               unique case (req.cmd)
                  CMD_FIND_ONE, CMD_FIND_COUNT: state_in = range_bad ? ST_REPLY : ST_SCAN;
                  CMD_MARK_USED, CMD_MARK_FREE, CMD_TEST: begin
                     state_in = idx_bad ? ST_REPLY : ST_MODIFY;
                  end
                  default: state_in = ST_REPLY;
               endcase
            end
         end
         ST_SCAN: begin
            priority if (run_full) begin
               state_in = ST_EMIT;
            end else if (cur_word != '0) begin
               state_in = ST_SCAN;
            end else if (ptr_at_end) begin
               state_in = ST_REPLY;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_MODIFY: state_in = ST_REPLY;
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (slot_free && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory access and result register loads.
   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      rs_in        = rs_ff;
      re_in        = re_ff;
      want_in      = want_ff;
      word_ptr_in  = word_ptr_ff;
      pend_in      = pend_ff;
      word_in      = word_ff;
      hit_cnt_in   = hit_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      rep_found_in = rep_found_ff;
      rep_bit_in   = rep_bit_ff;
      hit_wr       = 1'b0;
      hit_val      = BLK_W'({word_ptr_ff, low_idx});
      mem_req      = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_block_in = rsp_block_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               cmd_in       = req.cmd;
               idx_in       = req.block_index;
               rs_in        = req.range_start;
               re_in        = re_clip;
               want_in      = (req.cmd == CMD_FIND_COUNT) ? want_sat : CNT_W'(1);
               hit_cnt_in   = '0;
               out_cnt_in   = '0;
               pend_in      = 1'b1;
               rep_found_in = 1'b0;
               rep_bit_in   = 1'b0;
               unique case (req.cmd)
                  CMD_FIND_ONE, CMD_FIND_COUNT: begin
                     word_ptr_in    = WADDR_W'(req.range_start >> BIT_W);
                     mem_req.rd_en  = ~range_bad;
                     mem_req.addr   = WADDR_W'(req.range_start >> BIT_W);
                  end
                  CMD_MARK_USED, CMD_MARK_FREE, CMD_TEST: begin
                     word_ptr_in    = WADDR_W'(req.block_index >> BIT_W);
                     mem_req.rd_en  = ~idx_bad;
                     mem_req.addr   = WADDR_W'(req.block_index >> BIT_W);
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            priority if (run_full) begin
               pend_in = 1'b0;
            end else if (cur_word != '0) begin
               hit_wr     = 1'b1;
               word_in    = cur_word & ~onehot;
               pend_in    = 1'b0;
               hit_cnt_in = hit_cnt_ff + 1'b1;
            end else if (ptr_at_end) begin
               pend_in = 1'b0;
            end else begin
               word_ptr_in   = word_ptr_ff + 1'b1;
               pend_in       = 1'b1;
               mem_req.rd_en = 1'b1;
               mem_req.addr  = word_ptr_ff + 1'b1;
            end
         end
         ST_MODIFY: begin
            rep_found_in = 1'b1;
            if (cmd_ff == CMD_TEST) begin
               rep_bit_in = rd_data[idx_ff[BIT_W-1:0]];
            end else begin
               mem_req.wr_en = 1'b1;
               mem_req.addr  = word_ptr_ff;
               mem_req.wdata = (cmd_ff == CMD_MARK_FREE) ? (rd_data | idx_bit)
                                                         : (rd_data & ~idx_bit);
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = rep_found_ff;
               rsp_block_in = '0;
               rsp_bit_in   = rep_bit_ff;
               rsp_last_in  = 1'b1;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_block_in = hits_ff[out_cnt_ff[HIT_W-1:0]];
               rsp_bit_in   = 1'b0;
               rsp_last_in  = emit_last;
               out_cnt_in   = out_cnt_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      rs_ff        <= rs_in;
      re_ff        <= re_in;
      want_ff      <= want_in;
      word_ptr_ff  <= word_ptr_in;
      pend_ff      <= pend_in;
      word_ff      <= word_in;
      hit_cnt_ff   <= hit_cnt_in;
      out_cnt_ff   <= out_cnt_in;
      rep_found_ff <= rep_found_in;
      rep_bit_ff   <= rep_bit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_block_ff <= rsp_block_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_last_ff  <= rsp_last_in;
      if (hit_wr) begin
         hits_ff[hit_cnt_ff[HIT_W-1:0]] <= hit_val;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_block = rsp_block_ff;
   assign rsp_bit   = rsp_bit_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ----- hdl/free_block_bitmap_allocator.sv -----
// ============================================================================
// free_block_bitmap_allocator : one-bit-per-block free space allocator
// Keeps a free map (1 = free) in a word-wide memory and answers find, find
// count, mark and test commands over a stream interface.
// ============================================================================
//
//   Channel   Direction  Handshake               Payload
//   --------  ---------  ----------------------  ----------------------------------
//   req_*     in         req_tvalid/req_tready   tuser: cmd; tdata: index, range, count
//   rsp_*     out        rsp_tvalid/rsp_tready   tdata: found, block, bit; tlast
//
// After reset the map is written one 32-bit word per cycle, 32 words in all,
// and no command word is taken until that sweep is done.
// Commands run one at a time. A find reads one map word per cycle while the words
// it passes hold no free block, covering the words in the range (up to 32) and
// collecting free blocks, then sends one result per block; the memory read port sets the read pace.
// Mark and test commands pass through read, modify and reply steps, and wait
// in the reply step while the result register is not free.
// The result register lets the next command be accepted while the final
// result of the previous one still waits on a stalled rsp_tready.
//
module free_block_bitmap_allocator
   import fbba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Command words.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // block_index[9:0], range_start[19:10],
                                              // range_end[29:20], want_count[34:30]
   input  logic [CMD_W-1:0]      req_tuser,  // cmd[2:0]
   // Result words.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // found[0], result_block[10:1],
                                              // bit_value[11]
   output logic                  rsp_tlast
);

   req_type              req;
   map_req_type          mem_req;
   logic [WORD_BITS-1:0] rd_data;
   logic                 init_done;
   logic                 rsp_found;
   logic [BLK_W-1:0]     rsp_block;
   logic                 rsp_bit;

   // Unpack the command word; fields sit back to back from bit 0 up.
   assign req.cmd         = req_tuser;
   assign req.block_index = req_tdata[BLK_W-1:0];
   assign req.range_start = req_tdata[2*BLK_W-1:BLK_W];
   assign req.range_end   = req_tdata[3*BLK_W-1:2*BLK_W];
   assign req.want_count  = req_tdata[3*BLK_W+WANT_W-1:3*BLK_W];

   fbba_map_mem u_map (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .init_done (init_done)
   );

   fbba_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .init_done (init_done),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_found (rsp_found),
      .rsp_block (rsp_block),
      .rsp_bit   (rsp_bit),
      .rsp_last  (rsp_tlast)
   );

   // Pack the result word and pad it with zeros to a whole number of bytes.
   assign rsp_tdata = {{(RSP_DATA_W - BLK_W - 2){1'b0}}, rsp_bit, rsp_block, rsp_found};

`ifndef ASSERT_OFF
   // No command may start while the reset sweep still owns the map.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> init_done)
      else $error("command accepted during map initialization");

   // A single port never both reads and writes for the sequencer in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("map read and write issued together");

   // A not-found result carries block number zero and a zero bit value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[BLK_W:1] == '0 && !rsp_tdata[BLK_W+1]))
      else $error("not-found result with nonzero payload");

   // A tested bit only ever appears in a single, final result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[BLK_W+1]) |-> rsp_tlast)
      else $error("test result without last mark");
`endif

endmodule
